// ===== rtl/rbt_pkg.sv =====
`default_nettype none

package rbt_pkg;

    // Table size default and queue depths
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int IN_DEPTH        = 2;
    localparam int OUT_DEPTH       = 4;

    // Field widths
    localparam int CMD_W     = 2;
    localparam int HANDLE_W  = 8;
    localparam int IP_W      = 32;
    localparam int PORT_W    = 16;
    localparam int MS_W      = 16;
    localparam int SEQ_W     = 16;
    localparam int TRIES_W   = 4;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ACK  = 2'd2;

    // Event codes
    localparam logic [KIND_W-1:0] EV_FIRST  = 2'd0;
    localparam logic [KIND_W-1:0] EV_RETX   = 2'd1;
    localparam logic [KIND_W-1:0] EV_DROP   = 2'd2;
    localparam logic [KIND_W-1:0] EV_REJECT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_DELAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 2'd2;

    // Reset values of the configuration registers
    localparam logic [MS_W-1:0]    INIT_DELAY_RST   = 16'd500;
    localparam logic [MS_W-1:0]    MAX_DELAY_RST    = 16'd5000;
    localparam logic [TRIES_W-1:0] MAX_ATTEMPTS_RST = 4'd8;

    // Queued command
    typedef struct packed {
        logic [CMD_W-1:0]    kind;
        logic [HANDLE_W-1:0] handle;
        logic [IP_W-1:0]     ip;
        logic [PORT_W-1:0]   port;
        logic [MS_W-1:0]     elapsed;
        logic [SEQ_W-1:0]    ack_id;
    } cmd_t;

    // Result beat
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [SEQ_W-1:0]    seq;
        logic [HANDLE_W-1:0] handle;
        logic [IP_W-1:0]     ip;
        logic [PORT_W-1:0]   port;
        logic                last;
    } res_t;

    // One table entry
    typedef struct packed {
        logic [SEQ_W-1:0]    seq;
        logic [HANDLE_W-1:0] handle;
        logic [IP_W-1:0]     ip;
        logic [PORT_W-1:0]   port;
        logic [MS_W-1:0]     timer;
        logic [MS_W-1:0]     delay;
        logic [TRIES_W-1:0]  tries;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/rbt_front.sv =====
`default_nettype none

module rbt_front
    import rbt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [CMD_W-1:0]    command,
    input  wire logic [HANDLE_W-1:0] packet_handle,
    input  wire logic [IP_W-1:0]     target_ip,
    input  wire logic [PORT_W-1:0]   target_port,
    input  wire logic [MS_W-1:0]     elapsed_ms,
    input  wire logic [SEQ_W-1:0]    ack_id,
    output logic                     cmd_empty,
    input  wire logic                cmd_pop,
    output cmd_t                     cmd_data
);

    localparam int PTR_W = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
    localparam int CNT_W = $clog2(IN_DEPTH + 1);

    cmd_t             q_reg [IN_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept, known, wr_en, rd_en;

    // Accept a beat; unknown commands are dropped here and never queued
    assign full   = (cnt_reg == CNT_W'(IN_DEPTH));
    assign accept = push && !full;
    always_comb
    begin
        case (command)
            CMD_SEND, CMD_TICK, CMD_ACK: known = 1'b1;
            default:                     known = 1'b0;
        endcase
    end
    assign wr_en = accept && known;

    assign cmd_empty = (cnt_reg == '0);
    assign rd_en     = cmd_pop && !cmd_empty;
    assign cmd_data  = q_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(IN_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(IN_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= '{kind: command, handle: packet_handle, ip: target_ip,
                                   port: target_port, elapsed: elapsed_ms, ack_id: ack_id};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rbt_out_fifo.sv =====
`default_nettype none

module rbt_out_fifo
    import rbt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic res_push,
    input  res_t      res_in,
    output logic      res_full,
    output logic      empty,
    input  wire logic pop,
    output res_t      res_out
);

    localparam int PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    res_t             q_reg [OUT_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             wr_en, rd_en;

    assign res_full = (cnt_reg == CNT_W'(OUT_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign wr_en    = res_push && !res_full;
    assign rd_en    = pop && !empty;
    assign res_out  = q_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rbt_engine.sv =====
`default_nettype none

module rbt_engine
    import rbt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [CFG_W-1:0]     wr_data,
    input  wire logic                 cmd_empty,
    output logic                      cmd_pop,
    input  cmd_t                      cmd_data,
    output logic                      res_push,
    output res_t                      res_in,
    input  wire logic                 res_full
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SEND  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    // Configuration
    logic [MS_W-1:0]    init_delay_reg;
    logic [MS_W-1:0]    max_delay_reg;
    logic [TRIES_W-1:0] max_attempts_reg;

    // Control
    logic [1:0]             state_reg, state_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [SEQ_W-1:0]       next_seq_reg, next_seq_next;
    logic [CNT_W-1:0]       iss_cnt_reg, iss_cnt_next;
    logic                   p_vld_reg, p_vld_next;
    logic [IDX_W-1:0]       p_idx_reg, p_idx_next;
    logic                   pend_vld_reg, pend_vld_next;

    // Payload
    cmd_t   cur_reg, cur_next;
    res_t   pend_reg, pend_next;
    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    // Datapath
    logic             issue, adv, rd_en, scan_done;
    logic [IDX_W-1:0] iss_idx;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             p_live, is_tick, is_ack;
    logic [MS_W:0]    t_sum;
    logic [MS_W-1:0]  t_sat;
    logic             due, retx, ack_hit;
    logic [MS_W:0]    d_dbl;
    logic [MS_W-1:0]  d_new;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    entry_t           upd_entry;
    res_t             send_res, due_res;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_delay_reg   <= INIT_DELAY_RST;
            max_delay_reg    <= MAX_DELAY_RST;
            max_attempts_reg <= MAX_ATTEMPTS_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_INIT_DELAY:   init_delay_reg   <= wr_data;
                CFG_MAX_DELAY:    max_delay_reg    <= wr_data;
                CFG_MAX_ATTEMPTS: max_attempts_reg <= wr_data[TRIES_W-1:0];
                default:          ;
            endcase
        end
    end

    // Lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Scan issue stage
    assign is_tick = (cur_reg.kind == CMD_TICK);
    assign is_ack  = (cur_reg.kind == CMD_ACK);
    assign issue   = (state_reg == ST_SCAN) && (iss_cnt_reg != CNT_W'(TABLE_DEPTH));
    assign iss_idx = iss_cnt_reg[IDX_W-1:0];

    // Process stage: timer update, due check and backoff
    assign p_live  = p_vld_reg && valid_reg[p_idx_reg];
    assign t_sum   = {1'b0, rd_data_reg.timer} + {1'b0, cur_reg.elapsed};
    assign t_sat   = t_sum[MS_W] ? {MS_W{1'b1}} : t_sum[MS_W-1:0];
    assign due     = (state_reg == ST_SCAN) && is_tick && p_live && (t_sat >= rd_data_reg.delay);
    assign retx    = (rd_data_reg.tries < max_attempts_reg);
    assign d_dbl   = {rd_data_reg.delay, 1'b0};
    assign d_new   = (d_dbl > {1'b0, max_delay_reg}) ? max_delay_reg : d_dbl[MS_W-1:0];
    assign ack_hit = (state_reg == ST_SCAN) && is_ack && p_live
                     && (rd_data_reg.seq == cur_reg.ack_id);

    // A new due entry must first push the held one out
    assign adv       = !(due && pend_vld_reg && res_full);
    assign rd_en     = issue && adv;
    assign scan_done = (state_reg == ST_SCAN) && !issue && !p_vld_reg;

    always_comb
    begin
        upd_entry = rd_data_reg;
        if (due && retx)
        begin
            upd_entry.timer = '0;
            upd_entry.delay = d_new;
            upd_entry.tries = rd_data_reg.tries + 1'b1;
        end
        else
        begin
            upd_entry.timer = t_sat;
        end
    end

    assign due_res = '{kind: (retx ? EV_RETX : EV_DROP), seq: rd_data_reg.seq,
                       handle: rd_data_reg.handle, ip: rd_data_reg.ip,
                       port: rd_data_reg.port, last: 1'b0};

    assign send_res = '{kind: (free_found ? EV_FIRST : EV_REJECT), seq: next_seq_reg,
                        handle: cur_reg.handle, ip: cur_reg.ip, port: cur_reg.port,
                        last: 1'b1};

    // Table write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = p_idx_reg;
        mem_wdata = upd_entry;
        if (state_reg == ST_SEND)
        begin
            mem_we    = !res_full && free_found;
            mem_waddr = free_idx;
            mem_wdata = '{seq: next_seq_reg, handle: cur_reg.handle, ip: cur_reg.ip,
                          port: cur_reg.port, timer: '0, delay: init_delay_reg,
                          tries: '0};
        end
        else if ((state_reg == ST_SCAN) && is_tick && p_live && adv)
        begin
            mem_we = 1'b1;
        end
    end

    // Result push
    always_comb
    begin
        res_push = 1'b0;
        res_in   = send_res;
        case (state_reg)
            ST_SEND:
            begin
                res_push = !res_full;
            end
            ST_SCAN:
            begin
                res_push = due && pend_vld_reg && !res_full;
                res_in   = pend_reg;
            end
            ST_FLUSH:
            begin
                res_push = pend_vld_reg && !res_full;
                res_in   = pend_reg;
                res_in.last = 1'b1;
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        next_seq_next = next_seq_reg;
        iss_cnt_next  = iss_cnt_reg;
        p_vld_next    = p_vld_reg;
        p_idx_next    = p_idx_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        cur_next      = cur_reg;
        cmd_pop       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop      = 1'b1;
                    cur_next     = cmd_data;
                    iss_cnt_next = '0;
                    state_next   = (cmd_data.kind == CMD_SEND) ? ST_SEND : ST_SCAN;
                end
            end
            ST_SEND:
            begin
                if (!res_full)
                begin
                    if (free_found)
                    begin
                        valid_next[free_idx] = 1'b1;
                        next_seq_next        = next_seq_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (adv)
                begin
                    if (issue)
                    begin
                        iss_cnt_next = iss_cnt_reg + 1'b1;
                    end
                    p_vld_next = issue;
                    p_idx_next = iss_idx;
                    if (due)
                    begin
                        pend_vld_next = 1'b1;
                        pend_next     = due_res;
                        if (!retx)
                        begin
                            valid_next[p_idx_reg] = 1'b0;
                        end
                    end
                    if (ack_hit)
                    begin
                        valid_next[p_idx_reg] = 1'b0;
                    end
                end
                if (scan_done)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!res_full)
                begin
                    pend_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            next_seq_reg <= '0;
            iss_cnt_reg  <= '0;
            p_vld_reg    <= 1'b0;
            p_idx_reg    <= '0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            next_seq_reg <= next_seq_next;
            iss_cnt_reg  <= iss_cnt_next;
            p_vld_reg    <= p_vld_next;
            p_idx_reg    <= p_idx_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        pend_reg <= pend_next;
    end

    // Entry memory, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[iss_idx];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/retransmit_backoff_table_top.sv =====
// A send passes through the engine's idle and send states and pushes its one
// result from the send state; a tick or an ack scans the whole table, which
// reads one entry per cycle from its port unless a held result waits on a full
// result queue. The engine takes no new command until it is back in idle.
// Reset clears the queues, the valid bits, the next sequence id and loads the
// configuration defaults; no clearing pass is run over the entry memory.
`default_nettype none

module retransmit_backoff_table_top
    import rbt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [CFG_W-1:0]     wr_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [CMD_W-1:0]     command,
    input  wire logic [HANDLE_W-1:0]  packet_handle,
    input  wire logic [IP_W-1:0]      target_ip,
    input  wire logic [PORT_W-1:0]    target_port,
    input  wire logic [MS_W-1:0]      elapsed_ms,
    input  wire logic [SEQ_W-1:0]     ack_id,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [KIND_W-1:0]         event_kind,
    output logic [SEQ_W-1:0]          seq_id,
    output logic [HANDLE_W-1:0]       out_handle,
    output logic [IP_W-1:0]           out_ip,
    output logic [PORT_W-1:0]         out_port,
    output logic                      last
);

    logic cmd_empty, cmd_pop, res_push, res_full;
    cmd_t cmd_data;
    res_t res_in, res_out;

    // Front: take command beats and queue them
    rbt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .command       (command),
        .packet_handle (packet_handle),
        .target_ip     (target_ip),
        .target_port   (target_port),
        .elapsed_ms    (elapsed_ms),
        .ack_id        (ack_id),
        .cmd_empty     (cmd_empty),
        .cmd_pop       (cmd_pop),
        .cmd_data      (cmd_data)
    );

    // Back: table engine
    rbt_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd_data  (cmd_data),
        .res_push  (res_push),
        .res_in    (res_in),
        .res_full  (res_full)
    );

    // Result queue
    rbt_out_fifo u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res_in),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .res_out  (res_out)
    );

    assign event_kind = res_out.kind;
    assign seq_id     = res_out.seq;
    assign out_handle = res_out.handle;
    assign out_ip     = res_out.ip;
    assign out_port   = res_out.port;
    assign last       = res_out.last;

endmodule

`default_nettype wire

// ===== rtl/rbt_checker.sv =====
`default_nettype none

module rbt_props
    import rbt_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                full,
    input wire logic                empty,
    input wire logic                pop,
    input wire logic [KIND_W-1:0]   event_kind,
    input wire logic [SEQ_W-1:0]    seq_id,
    input wire logic [HANDLE_W-1:0] out_handle,
    input wire logic [IP_W-1:0]     out_ip,
    input wire logic [PORT_W-1:0]   out_port,
    input wire logic                last
);

    logic [SEQ_W-1:0] exp_seq_reg, exp_seq_next;

    // Expected id of the next send, tracked from first-transmit beats
    always_comb
    begin
        exp_seq_next = exp_seq_reg;
        if (pop && !empty && (event_kind == EV_FIRST))
        begin
            exp_seq_next = seq_id + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_seq_reg <= '0;
        end
        else
        begin
            exp_seq_reg <= exp_seq_next;
        end
    end

    // Both queues come out of reset with nothing in them
    a_empty_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> (empty && !full))
        else $error("queues not empty after reset");

    // A waiting result holds while it is not taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(event_kind) && $stable(seq_id) && $stable(out_handle)
             && $stable(out_ip) && $stable(out_port) && $stable(last)))
        else $error("waiting result changed");

    // A send gives exactly one result, so it is always the last one
    a_send_single: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && ((event_kind == EV_FIRST) || (event_kind == EV_REJECT))) |-> last)
        else $error("send result not marked last");

    // Sends take ids in order; a rejected send shows the id it would take
    a_seq_order: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && ((event_kind == EV_FIRST) || (event_kind == EV_REJECT)))
            |-> (seq_id == exp_seq_reg))
        else $error("send sequence id out of order");

    // A waiting result is fully defined
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !$isunknown({event_kind, seq_id, out_handle, out_ip, out_port, last}))
        else $error("waiting result has unknown bits");

endmodule

bind retransmit_backoff_table_top rbt_props u_rbt_props (.*);

`default_nettype wire
